>>> hdl/lst_pkg.sv
`timescale 1ns / 1ps
package lst_pkg;

	typedef enum logic [3:0] {
		K_CREATE  = 4'd0,
		K_DELETE  = 4'd1,
		K_MOVE    = 4'd2,
		K_RESIZE  = 4'd3,
		K_SURFACE = 4'd4,
		K_FLAGS   = 4'd5,
		K_ALPHA   = 4'd6,
		K_FIND    = 4'd7,
		K_TOP     = 4'd8
	} kind_t;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;

	localparam logic [1:0] REG_VISIBLE     = 2'd0;
	localparam logic [1:0] REG_ACTIVE      = 2'd1;
	localparam logic [1:0] REG_TRANSPARENT = 2'd2;

	localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

	typedef struct packed {
		logic [3:0]         kind;
		logic [31:0]        layer_id;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic [31:0]        new_width;
		logic [31:0]        new_height;
		logic [31:0]        surface_handle;
		logic [31:0]        new_flags;
		logic [7:0]         new_alpha;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [3:0]         slot;
		logic [31:0]        out_id;
		logic [3:0]         out_z;
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic [31:0]        out_width;
		logic [31:0]        out_height;
		logic [31:0]        out_flags;
		logic [7:0]         out_alpha;
		logic [31:0]        out_surface;
		logic [4:0]         live_count;
	} rsp_t;

	// controller -> datapath
	typedef struct packed {
		logic search;   // latch request, register match/free/top results
		logic execute;  // apply the operation and form the result
	} cmd_t;

endpackage

>>> hdl/lst_ctrl.sv
`timescale 1ns / 1ps
module lst_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	output lst_pkg::cmd_t   cmd
);
	import lst_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_EXEC} state_t;
	state_t state_q;

	assign cmd.search  = start && (state_q == S_IDLE);
	assign cmd.execute = (state_q == S_EXEC);
	assign busy        = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: if (start) state_q <= S_EXEC;
				S_EXEC: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

>>> hdl/lst_dp.sv
`timescale 1ns / 1ps
module lst_dp #(
	parameter int MAX_LAYERS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  lst_pkg::cmd_t cmd,
	input  lst_pkg::req_t req,
	input  logic          cfg_we,
	input  logic [1:0]    cfg_index,
	input  logic [4:0]    cfg_data,
	output logic          done,
	output lst_pkg::rsp_t rsp
);
	import lst_pkg::*;

	localparam int SW = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
	// live count is a 5-bit wrapping counter whatever the table size
	localparam int CW = 5;

	logic [MAX_LAYERS-1:0] valid_q;
	logic [31:0] id_q [MAX_LAYERS];
	logic [31:0] x_q [MAX_LAYERS];
	logic [31:0] y_q [MAX_LAYERS];
	logic [31:0] w_q [MAX_LAYERS];
	logic [31:0] h_q [MAX_LAYERS];
	logic [31:0] fl_q [MAX_LAYERS];
	logic [7:0]  al_q [MAX_LAYERS];
	logic [31:0] sf_q [MAX_LAYERS];
	logic [31:0] ctr_q;
	logic [CW-1:0] count_q;
	logic [4:0] vis_q, act_q, trn_q;

	// search stage
	req_t        req_s1;
	logic        hit_s1;
	logic [SW-1:0] idx_s1;

	logic          f_hit, m_hit, t_hit;
	logic [SW-1:0] f_idx, m_idx, t_idx;

	always_comb begin
		f_hit = 1'b0; f_idx = '0;
		m_hit = 1'b0; m_idx = '0;
		t_hit = 1'b0; t_idx = '0;
		for (int i = MAX_LAYERS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				f_hit = 1'b1; f_idx = SW'(i);
			end
			if (valid_q[i] && id_q[i] == req.layer_id) begin
				m_hit = 1'b1; m_idx = SW'(i);
			end
		end
		for (int i = 0; i < MAX_LAYERS; i++) begin
			if (valid_q[i] && fl_q[i][vis_q]) begin
				t_hit = 1'b1; t_idx = SW'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.search) begin
			req_s1 <= req;
			case (kind_t'(req.kind))
				K_CREATE: begin hit_s1 <= f_hit; idx_s1 <= f_idx; end
				K_TOP:    begin hit_s1 <= t_hit; idx_s1 <= t_idx; end
				default:  begin hit_s1 <= m_hit; idx_s1 <= m_idx; end
			endcase
		end
	end

	logic          ok;
	logic [31:0]   ctr_inc;
	logic [CW-1:0] cnt_next;
	assign ctr_inc = ctr_q + 32'd1;
	assign ok = hit_s1 && (req_s1.kind <= 4'(K_TOP));

	always_comb begin
		cnt_next = count_q;
		if (ok && req_s1.kind == 4'(K_CREATE)) cnt_next = count_q + CW'(1);
		else if (ok && req_s1.kind == 4'(K_DELETE) && count_q != '0)
			cnt_next = count_q - CW'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			ctr_q   <= '0;
			count_q <= '0;
			vis_q   <= 5'd0;
			act_q   <= 5'd1;
			trn_q   <= 5'd2;
			done    <= 1'b0;
			for (int i = 0; i < MAX_LAYERS; i++) begin
				id_q[i] <= '0; x_q[i] <= '0; y_q[i] <= '0; w_q[i] <= '0;
				h_q[i] <= '0; fl_q[i] <= '0; al_q[i] <= '0; sf_q[i] <= '0;
			end
		end else begin
			done <= cmd.execute;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_VISIBLE:     vis_q <= cfg_data;
					REG_ACTIVE:      act_q <= cfg_data;
					REG_TRANSPARENT: trn_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.execute && ok) begin
				count_q <= cnt_next;
				case (kind_t'(req_s1.kind))
					K_CREATE: begin
						valid_q[idx_s1] <= 1'b1;
						id_q[idx_s1] <= ctr_inc;
						ctr_q <= (ctr_inc == '0) ? 32'd1 : ctr_inc;
						x_q[idx_s1] <= '0; y_q[idx_s1] <= '0;
						w_q[idx_s1] <= '0; h_q[idx_s1] <= '0;
						fl_q[idx_s1] <= (32'd1 << vis_q) | (32'd1 << act_q);
						al_q[idx_s1] <= ALPHA_OPAQUE;
						sf_q[idx_s1] <= '0;
					end
					K_DELETE: begin
						valid_q[idx_s1] <= 1'b0;
						id_q[idx_s1] <= '0; x_q[idx_s1] <= '0; y_q[idx_s1] <= '0;
						w_q[idx_s1] <= '0; h_q[idx_s1] <= '0; fl_q[idx_s1] <= '0;
						al_q[idx_s1] <= '0; sf_q[idx_s1] <= '0;
					end
					K_MOVE: begin
						x_q[idx_s1] <= req_s1.pos_x; y_q[idx_s1] <= req_s1.pos_y;
					end
					K_RESIZE: begin
						w_q[idx_s1] <= req_s1.new_width; h_q[idx_s1] <= req_s1.new_height;
					end
					K_SURFACE: sf_q[idx_s1] <= req_s1.surface_handle;
					K_FLAGS:   fl_q[idx_s1] <= req_s1.new_flags;
					K_ALPHA: begin
						al_q[idx_s1] <= req_s1.new_alpha;
						fl_q[idx_s1] <= fl_q[idx_s1] | (32'd1 << trn_q);
					end
					default: ;
				endcase
			end
		end
	end

	// result: record after the step (delete reports the old record)
	rsp_t rsp_next;

	always_comb begin
		rsp_next = '0;
		rsp_next.live_count = 5'(cnt_next);
		if (!ok) begin
			rsp_next.status = (req_s1.kind == 4'(K_CREATE)) ? ST_FULL : ST_NOT_FOUND;
		end else begin
			rsp_next.status      = ST_OK;
			rsp_next.slot        = 4'(idx_s1);
			rsp_next.out_z       = 4'(idx_s1);
			rsp_next.out_id      = id_q[idx_s1];
			rsp_next.out_x       = x_q[idx_s1];
			rsp_next.out_y       = y_q[idx_s1];
			rsp_next.out_width   = w_q[idx_s1];
			rsp_next.out_height  = h_q[idx_s1];
			rsp_next.out_flags   = fl_q[idx_s1];
			rsp_next.out_alpha   = al_q[idx_s1];
			rsp_next.out_surface = sf_q[idx_s1];
			case (kind_t'(req_s1.kind))
				K_CREATE: begin
					rsp_next.out_id = ctr_inc;
					rsp_next.out_x = '0; rsp_next.out_y = '0;
					rsp_next.out_width = '0; rsp_next.out_height = '0;
					rsp_next.out_flags = (32'd1 << vis_q) | (32'd1 << act_q);
					rsp_next.out_alpha = ALPHA_OPAQUE;
					rsp_next.out_surface = '0;
				end
				K_MOVE: begin
					rsp_next.out_x = req_s1.pos_x; rsp_next.out_y = req_s1.pos_y;
				end
				K_RESIZE: begin
					rsp_next.out_width = req_s1.new_width;
					rsp_next.out_height = req_s1.new_height;
				end
				K_SURFACE: rsp_next.out_surface = req_s1.surface_handle;
				K_FLAGS:   rsp_next.out_flags = req_s1.new_flags;
				K_ALPHA: begin
					rsp_next.out_alpha = req_s1.new_alpha;
					rsp_next.out_flags = fl_q[idx_s1] | (32'd1 << trn_q);
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.execute) begin
			rsp <= rsp_next;
		end
	end
endmodule

>>> hdl/layer_slot_table_top.sv
`timescale 1ns / 1ps
// The result strobe is high in the cycle after the execute cycle; busy is high
// for the execute cycle only, and a start in that cycle is not taken.
// The start cycle searches all slots at once and registers the priority-encoded
// hit: lowest matching id or free slot, or highest visible slot for a top query.
// Reset (arst_n low) empties the table, zeroes the id counter and live count,
// and restores flag bit positions 0, 1, 2. The receiver cannot stall results.
module layer_slot_table_top #(
	parameter int MAX_LAYERS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  lst_pkg::req_t req,
	output logic          result_valid,
	output lst_pkg::rsp_t result,
	input  logic          cfg_we,
	input  logic [1:0]    cfg_index,
	input  logic [4:0]    cfg_data
);
	import lst_pkg::*;

	cmd_t cmd;

	// Sequence each transaction: search cycle, then execute cycle.
	lst_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd)
	);

	// Hold the slot table and form the result.
	lst_dp #(.MAX_LAYERS(MAX_LAYERS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .req(req),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.done(result_valid), .rsp(result)
	);

	// A result strobe follows the execute cycle of every accepted transaction.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> ##1 result_valid)
		else $error("missing result");

	// No result without an execute cycle (busy high) ahead of it.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy))
		else $error("spurious result");

	// Live count never exceeds table size (a 5-bit count cannot exceed a larger table).
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> ((MAX_LAYERS >= 32) || (int'(result.live_count) <= MAX_LAYERS)))
		else $error("live count out of range");
endmodule
